@@ rtl/core/kvlp_pkg.sv @@
// kvlp_pkg: shared constants and types for the key/value line parser
// character codes, result kinds, sequencer states and line status flags
// no dependencies
package kvlp_pkg;

	localparam int LINE_MAX_DEF = 64;

	localparam logic [7:0] CH_NL   = 8'h0a;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_DQ   = 8'h22;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SQ   = 8'h27;
	localparam logic [7:0] CH_EQ   = 8'h3d;

	typedef enum logic [1:0] {
		KIND_KEY   = 2'd0,
		KIND_VALUE = 2'd1,
		KIND_OVF   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_CLOSE = 2'd1,
		ST_KEY   = 2'd2,
		ST_VALUE = 2'd3
	} state_t;

	typedef struct packed {
		logic found_s;
		logic hash;
		logic found_eq;
		logic key_ok;
		logic ovf;
	} line_flags_t;

endpackage

@@ rtl/core/kvlp_line_ram.sv @@
// kvlp_line_ram: line buffer, one write port and one registered read port
// depends on kvlp_pkg for the default depth
module kvlp_line_ram #(
	parameter int LINE_MAX = kvlp_pkg::LINE_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(LINE_MAX)-1:0] waddr,
	input  logic [7:0]                  wdata,
	input  logic                        re,
	input  logic [$clog2(LINE_MAX)-1:0] raddr,
	output logic [7:0]                  rdata
);

	logic [7:0] mem [LINE_MAX];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/kvlp_scan.sv @@
// kvlp_scan: stores incoming bytes and tracks key start, '=' position,
// key end, first value byte and the last two bytes of the current line
// depends on kvlp_pkg; drives the write port of kvlp_line_ram
module kvlp_scan #(
	parameter int LINE_MAX = kvlp_pkg::LINE_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [7:0]                    byte_in,
	input  logic                          clear,
	output logic                          ram_we,
	output logic [$clog2(LINE_MAX)-1:0]   ram_waddr,
	output logic [7:0]                    ram_wdata,
	output kvlp_pkg::line_flags_t         flags,
	output logic [$clog2(LINE_MAX+1)-1:0] s_pos,
	output logic [$clog2(LINE_MAX+1)-1:0] eq_pos,
	output logic [$clog2(LINE_MAX+1)-1:0] ke_pos,
	output logic [$clog2(LINE_MAX+1)-1:0] len,
	output logic [7:0]                    vfirst,
	output logic [7:0]                    last_byte,
	output logic [7:0]                    prev_byte
);

	localparam int AW = $clog2(LINE_MAX);
	localparam int PW = $clog2(LINE_MAX + 1);

	kvlp_pkg::line_flags_t flags_q;
	logic [PW-1:0] len_q;
	logic [PW-1:0] s_q;
	logic [PW-1:0] eq_q;
	logic [PW-1:0] ke_q;
	logic [7:0]    vfirst_q;
	logic [7:0]    last_q;
	logic [7:0]    prev_q;

	logic room;
	logic store;
	logic blank3;
	logic trim2;
	logic is_eq;
	logic s_now;
	logic s_upd;
	logic eq_upd;
	logic key_upd;

	always_comb begin
		room    = len_q < PW'(LINE_MAX);
		store   = push && room;
		trim2   = (byte_in == kvlp_pkg::CH_SP) || (byte_in == kvlp_pkg::CH_TAB);
		blank3  = trim2 || (byte_in == kvlp_pkg::CH_CR);
		is_eq   = byte_in == kvlp_pkg::CH_EQ;
		s_upd   = !flags_q.found_s && !blank3;
		s_now   = flags_q.found_s || !blank3;
		eq_upd  = s_now && !flags_q.found_eq && is_eq;
		key_upd = s_now && !flags_q.found_eq && !is_eq && !trim2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			len_q   <= '0;
		end else if (clear) begin
			flags_q <= '0;
			len_q   <= '0;
		end else if (push) begin
			if (room) begin
				len_q <= len_q + PW'(1);
				if (s_upd) begin
					flags_q.found_s <= 1'b1;
					flags_q.hash    <= byte_in == kvlp_pkg::CH_HASH;
				end
				if (eq_upd) begin
					flags_q.found_eq <= 1'b1;
				end
				if (key_upd) begin
					flags_q.key_ok <= 1'b1;
				end
			end else begin
				flags_q.ovf <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			if (s_upd) begin
				s_q <= len_q;
			end
			if (eq_upd) begin
				eq_q <= len_q;
			end
			if (key_upd) begin
				ke_q <= len_q + PW'(1);
			end
			if (flags_q.found_eq && (len_q == eq_q + PW'(1))) begin
				vfirst_q <= byte_in;
			end
			prev_q <= last_q;
			last_q <= byte_in;
		end
	end

	assign ram_we    = store;
	assign ram_waddr = len_q[AW-1:0];
	assign ram_wdata = byte_in;
	assign flags     = flags_q;
	assign s_pos     = s_q;
	assign eq_pos    = eq_q;
	assign ke_pos    = ke_q;
	assign len       = len_q;
	assign vfirst    = vfirst_q;
	assign last_byte = last_q;
	assign prev_byte = prev_q;

endmodule

@@ rtl/core/kvlp_reader.sv @@
// kvlp_reader: line-end sequencer; works out key and value ranges, reads
// the line buffer one byte a cycle while its output/skid pair has room
// to hold results; depends on kvlp_pkg; drives the read port of kvlp_line_ram
module kvlp_reader #(
	parameter int LINE_MAX = kvlp_pkg::LINE_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          close_req,
	input  kvlp_pkg::line_flags_t         flags,
	input  logic [$clog2(LINE_MAX+1)-1:0] s_pos,
	input  logic [$clog2(LINE_MAX+1)-1:0] eq_pos,
	input  logic [$clog2(LINE_MAX+1)-1:0] ke_pos,
	input  logic [$clog2(LINE_MAX+1)-1:0] len,
	input  logic [7:0]                    vfirst,
	input  logic [7:0]                    last_byte,
	input  logic [7:0]                    prev_byte,
	output logic                          idle,
	output logic                          line_clear,
	output logic                          ram_re,
	output logic [$clog2(LINE_MAX)-1:0]   ram_raddr,
	input  logic [7:0]                    ram_rdata,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    kind,
	output logic [7:0]                    out_byte,
	output logic                          entry_last
);

	localparam int AW = $clog2(LINE_MAX);
	localparam int PW = $clog2(LINE_MAX + 1);
	localparam int EW = PW + 1;

	kvlp_pkg::state_t state_q, state_d;
	logic [PW-1:0] ptr_q, ptr_d;
	logic [PW-1:0] ke_q, ke_d;
	logic [PW-1:0] vs_q, vs_d;
	logic [PW-1:0] ve_q, ve_d;

	logic            pend_s1;
	kvlp_pkg::kind_t kind_s1;
	logic            last_s1;
	logic            ovf_s1;

	logic            out_valid_q;
	kvlp_pkg::kind_t out_kind_q;
	logic [7:0]      out_byte_q;
	logic            out_last_q;
	logic            skid_valid_q;
	kvlp_pkg::kind_t skid_kind_q;
	logic [7:0]      skid_byte_q;
	logic            skid_last_q;

	logic            issue;
	logic            iss_ovf;
	logic            iss_last;
	kvlp_pkg::kind_t iss_kind;
	logic            pop;
	logic            can_issue;
	logic [7:0]      pend_byte;
	logic            line_ok;
	logic [PW-1:0]   ptr_inc;

	logic [EW-1:0] vs0;
	logic [EW-1:0] ve1;
	logic          cr_drop;
	logic [7:0]    tail;
	logic          quoted;

	// value range with trailing cr and enclosing quotes removed
	always_comb begin
		vs0     = EW'(eq_pos) + EW'(1);
		cr_drop = (EW'(len) > vs0) && (last_byte == kvlp_pkg::CH_CR);
		ve1     = cr_drop ? EW'(len) - EW'(1) : EW'(len);
		tail    = cr_drop ? prev_byte : last_byte;
		quoted  = (ve1 >= vs0 + EW'(2))
			&& (((vfirst == kvlp_pkg::CH_DQ) && (tail == kvlp_pkg::CH_DQ))
			|| ((vfirst == kvlp_pkg::CH_SQ) && (tail == kvlp_pkg::CH_SQ)));
		line_ok = flags.found_s && !flags.hash && flags.found_eq && flags.key_ok;
	end

	always_comb begin
		pop       = out_valid_q && !out_stall;
		can_issue = (2'(out_valid_q) + 2'(skid_valid_q) + 2'(pend_s1)) <= (2'(pop) + 2'd1);
		ptr_inc   = ptr_q + PW'(1);
	end

	always_comb begin
		state_d    = state_q;
		ptr_d      = ptr_q;
		ke_d       = ke_q;
		vs_d       = vs_q;
		ve_d       = ve_q;
		issue      = 1'b0;
		iss_ovf    = 1'b0;
		iss_last   = 1'b0;
		iss_kind   = kvlp_pkg::KIND_KEY;
		line_clear = 1'b0;
		case (state_q)
			kvlp_pkg::ST_IDLE: begin
				if (close_req) begin
					state_d = kvlp_pkg::ST_CLOSE;
				end
			end
			kvlp_pkg::ST_CLOSE: begin
				if (flags.ovf) begin
					if (can_issue) begin
						issue      = 1'b1;
						iss_ovf    = 1'b1;
						iss_kind   = kvlp_pkg::KIND_OVF;
						line_clear = 1'b1;
						state_d    = kvlp_pkg::ST_IDLE;
					end
				end else if (!line_ok) begin
					line_clear = 1'b1;
					state_d    = kvlp_pkg::ST_IDLE;
				end else begin
					line_clear = 1'b1;
					ptr_d      = s_pos;
					ke_d       = ke_pos;
					vs_d       = quoted ? PW'(vs0 + EW'(1)) : PW'(vs0);
					ve_d       = quoted ? PW'(ve1 - EW'(1)) : PW'(ve1);
					state_d    = kvlp_pkg::ST_KEY;
				end
			end
			kvlp_pkg::ST_KEY: begin
				if (can_issue) begin
					issue    = 1'b1;
					iss_kind = kvlp_pkg::KIND_KEY;
					iss_last = (ptr_inc == ke_q) && (vs_q == ve_q);
					if (ptr_inc == ke_q) begin
						if (vs_q == ve_q) begin
							state_d = kvlp_pkg::ST_IDLE;
						end else begin
							ptr_d   = vs_q;
							state_d = kvlp_pkg::ST_VALUE;
						end
					end else begin
						ptr_d = ptr_inc;
					end
				end
			end
			kvlp_pkg::ST_VALUE: begin
				if (can_issue) begin
					issue    = 1'b1;
					iss_kind = kvlp_pkg::KIND_VALUE;
					iss_last = ptr_inc == ve_q;
					ptr_d    = ptr_inc;
					if (ptr_inc == ve_q) begin
						state_d = kvlp_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = kvlp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kvlp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		ke_q  <= ke_d;
		vs_q  <= vs_d;
		ve_q  <= ve_d;
		if (issue) begin
			kind_s1 <= iss_kind;
			last_s1 <= iss_last;
			ovf_s1  <= iss_ovf;
		end
	end

	assign pend_byte = ovf_s1 ? 8'd0 : ram_rdata;

	// output register and skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (pop || !out_valid_q) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= pend_s1;
				end else begin
					out_valid_q <= pend_s1;
				end
			end else if (pend_s1) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_kind_q <= skid_kind_q;
				out_byte_q <= skid_byte_q;
				out_last_q <= skid_last_q;
				if (pend_s1) begin
					skid_kind_q <= kind_s1;
					skid_byte_q <= pend_byte;
					skid_last_q <= last_s1;
				end
			end else if (pend_s1) begin
				out_kind_q <= kind_s1;
				out_byte_q <= pend_byte;
				out_last_q <= last_s1;
			end
		end else if (pend_s1) begin
			skid_kind_q <= kind_s1;
			skid_byte_q <= pend_byte;
			skid_last_q <= last_s1;
		end
	end

	assign idle       = state_q == kvlp_pkg::ST_IDLE;
	assign ram_re     = issue && !iss_ovf;
	assign ram_raddr  = ptr_q[AW-1:0];
	assign out_valid  = out_valid_q;
	assign kind       = out_kind_q;
	assign out_byte   = out_byte_q;
	assign entry_last = out_last_q;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds data while output register is empty");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 && out_valid_q && out_stall |-> !skid_valid_q)
		else $error("read data arrives with no free output slot");

	a_ovf_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_kind_q == kvlp_pkg::KIND_OVF) |-> (out_byte_q == 8'd0) && !out_last_q)
		else $error("overflow result carries data or entry end");

	a_read_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (state_q == kvlp_pkg::ST_KEY) || (state_q == kvlp_pkg::ST_VALUE))
		else $error("line buffer read outside key or value readout");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		line_clear |=> state_q != kvlp_pkg::ST_CLOSE)
		else $error("sequencer stays in line close after clearing the line");
`endif

endmodule

@@ rtl/core/key_value_line_parser.sv @@
// key_value_line_parser: top level of the key/value line parser
// instantiates kvlp_scan, kvlp_line_ram and kvlp_reader; uses kvlp_pkg
//
// text channel: text_valid/text_stall carry text_byte and end_of_content.
// a transaction with text_byte 10, or with end_of_content set, ends the line.
// bytes are taken one per cycle while a line is being collected; the line
// buffer holds LINE_MAX bytes, later bytes of a longer line are dropped.
// result channel: result_valid/result_stall carry kind, out_byte, entry_last.
// at line end text_stall rises for range evaluation and stays high while
// key and value bytes are read from the line buffer, one a cycle while
// the output register and its skid stage have room; each byte passes the
// line buffer's read register into the output register or its skid stage.
// an overflowed line gives one overflow result.
// the line buffer has a single read port, which sets the readout rate.
// when result_stall is high, readout pauses once the output register and
// its skid stage are full; no result is lost or repeated.
// arst_n clears the line length, line flags, sequencer and output valids.
// a skipped line (blank, comment, no key or no '=') gives no result.
module key_value_line_parser #(
	parameter int LINE_MAX = kvlp_pkg::LINE_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_content,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic       entry_last
);

	localparam int AW = $clog2(LINE_MAX);
	localparam int PW = $clog2(LINE_MAX + 1);

	logic                  accept;
	logic                  is_nl;
	logic                  push;
	logic                  close_req;
	logic                  idle;
	logic                  line_clear;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [7:0]            ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [7:0]            ram_rdata;
	kvlp_pkg::line_flags_t flags;
	logic [PW-1:0]         s_pos;
	logic [PW-1:0]         eq_pos;
	logic [PW-1:0]         ke_pos;
	logic [PW-1:0]         len;
	logic [7:0]            vfirst;
	logic [7:0]            last_byte;
	logic [7:0]            prev_byte;

	assign text_stall = !idle;
	assign accept     = text_valid && !text_stall;
	assign is_nl      = text_byte == kvlp_pkg::CH_NL;
	assign push       = accept && !is_nl;
	assign close_req  = accept && (is_nl || end_of_content);

	kvlp_scan #(
		.LINE_MAX(LINE_MAX)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.byte_in   (text_byte),
		.clear     (line_clear),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.flags     (flags),
		.s_pos     (s_pos),
		.eq_pos    (eq_pos),
		.ke_pos    (ke_pos),
		.len       (len),
		.vfirst    (vfirst),
		.last_byte (last_byte),
		.prev_byte (prev_byte)
	);

	kvlp_line_ram #(
		.LINE_MAX(LINE_MAX)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	kvlp_reader #(
		.LINE_MAX(LINE_MAX)
	) u_reader (
		.clk        (clk),
		.arst_n     (arst_n),
		.close_req  (close_req),
		.flags      (flags),
		.s_pos      (s_pos),
		.eq_pos     (eq_pos),
		.ke_pos     (ke_pos),
		.len        (len),
		.vfirst     (vfirst),
		.last_byte  (last_byte),
		.prev_byte  (prev_byte),
		.idle       (idle),
		.line_clear (line_clear),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.out_valid  (result_valid),
		.out_stall  (result_stall),
		.kind       (kind),
		.out_byte   (out_byte),
		.entry_last (entry_last)
	);

endmodule

@@ tb/key_value_line_parser_tb.sv @@
// key_value_line_parser_tb: self-checking testbench for the key/value line parser
// a scoreboard class splits each buffered line into expected key, value and overflow results
// depends on kvlp_pkg and key_value_line_parser

typedef struct packed {
	kvlp_pkg::kind_t kind;
	logic [7:0]      data;
	logic            last;
} entry_byte_t;

class entry_scoreboard;
	logic [7:0]  line_buf [kvlp_pkg::LINE_MAX_DEF];
	int          line_len;
	bit          line_ovf;
	entry_byte_t expected_bytes [$];
	int          errors;

	function new();
		line_len = 0;
		line_ovf = 1'b0;
		errors = 0;
	endfunction

	function int outstanding();
		return expected_bytes.size();
	endfunction

	function void add_expected(kvlp_pkg::kind_t k, logic [7:0] b, logic last);
		entry_byte_t e;
		e.kind = k;
		e.data = b;
		e.last = last;
		expected_bytes.push_back(e);
	endfunction

	function void split_line();
		int len, s, eq, ke, vs, ve;
		bit ovf;
		len = line_len;
		ovf = line_ovf;
		line_len = 0;
		line_ovf = 1'b0;
		if (ovf) begin
			add_expected(kvlp_pkg::KIND_OVF, 8'h00, 1'b0);
			return;
		end
		s = 0;
		while (s < len
			&& line_buf[s] inside {kvlp_pkg::CH_SP, kvlp_pkg::CH_TAB, kvlp_pkg::CH_CR})
			s++;
		if (s >= len || line_buf[s] == kvlp_pkg::CH_HASH)
			return;
		eq = s;
		while (eq < len && line_buf[eq] != kvlp_pkg::CH_EQ)
			eq++;
		if (eq >= len)
			return;
		ke = eq;
		while (ke > s && line_buf[ke - 1] inside {kvlp_pkg::CH_SP, kvlp_pkg::CH_TAB})
			ke--;
		if (ke == s)
			return;
		vs = eq + 1;
		ve = len;
		if (ve > vs && line_buf[ve - 1] == kvlp_pkg::CH_CR)
			ve--;
		if (ve >= vs + 2 && line_buf[vs] == line_buf[ve - 1]
			&& line_buf[vs] inside {kvlp_pkg::CH_DQ, kvlp_pkg::CH_SQ}) begin
			vs++;
			ve--;
		end
		for (int i = s; i < ke; i++)
			add_expected(kvlp_pkg::KIND_KEY, line_buf[i], (i + 1 == ke) && (vs == ve));
		for (int i = vs; i < ve; i++)
			add_expected(kvlp_pkg::KIND_VALUE, line_buf[i], i + 1 == ve);
	endfunction

	function void note_text_byte(logic [7:0] b, logic eoc);
		if (b == kvlp_pkg::CH_NL) begin
			split_line();
		end else begin
			if (line_len < kvlp_pkg::LINE_MAX_DEF) begin
				line_buf[line_len] = b;
				line_len++;
			end else begin
				line_ovf = 1'b1;
			end
			if (eoc)
				split_line();
		end
	endfunction

	function void check_entry_byte(logic [1:0] k, logic [7:0] b, logic last);
		entry_byte_t want;
		if (expected_bytes.size() == 0) begin
			errors++;
			$display("%0t: unexpected result kind %0d byte %02h last %b", $time, k, b, last);
			return;
		end
		want = expected_bytes.pop_front();
		if (k !== want.kind) begin
			errors++;
			$display("%0t: kind expected %0d actual %0d", $time, want.kind, k);
		end
		if (b !== want.data) begin
			errors++;
			$display("%0t: out_byte expected %02h actual %02h", $time, want.data, b);
		end
		if (last !== want.last) begin
			errors++;
			$display("%0t: entry_last expected %b actual %b", $time, want.last, last);
		end
	endfunction
endclass

module key_value_line_parser_tb;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_BYTES = 150;
	localparam int DRAIN_CYCLES = 20;

	typedef enum {
		SHAPE_ENTRY,
		SHAPE_COMMENT,
		SHAPE_BLANK,
		SHAPE_NO_EQ,
		SHAPE_EMPTY_KEY,
		SHAPE_NOISE,
		SHAPE_FULL,
		SHAPE_OVERFLOW
	} line_shape_t;

	logic       clk;
	logic       arst_n;
	logic       text_valid;
	logic       text_stall;
	logic [7:0] text_byte;
	logic       end_of_content;
	logic       result_valid;
	logic       result_stall;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       entry_last;

	entry_scoreboard sb;
	int burst_left;
	int random_bytes;
	int cycle_count = 0;
	bit hold_req;

	key_value_line_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_byte(text_byte),
		.end_of_content(end_of_content),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.out_byte(out_byte),
		.entry_last(entry_last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
			sb.check_entry_byte(kind, out_byte, entry_last);
	end

	// receiver stall pattern, with one long hold when asked
	initial begin
		int mode, span;
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 60);
			for (int i = 0; i < span && !hold_req; i++) begin
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 9) < 4);
					2: result_stall <= (i % 3 == 0);
					default: result_stall <= ($urandom_range(0, 3) != 0);
				endcase
				@(negedge clk);
			end
		end
	end

	task automatic send_text_byte(input logic [7:0] b, input logic eoc);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				text_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		text_valid <= 1'b1;
		text_byte <= b;
		end_of_content <= eoc;
		do @(posedge clk); while (text_stall !== 1'b0);
		sb.note_text_byte(b, eoc);
		@(negedge clk);
	endtask

	task automatic send_str(input string s, input logic eoc_last);
		for (int i = 0; i < s.len(); i++)
			send_text_byte(s[i], eoc_last && (i == s.len() - 1));
	endtask

	task automatic wait_drained();
		text_valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (sb.outstanding() != 0);
	endtask

	function automatic logic [7:0] any_byte();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		return (c == kvlp_pkg::CH_NL) ? 8'hca : c;
	endfunction

	function automatic logic [7:0] blank_char(input bit with_cr);
		case ($urandom_range(0, with_cr ? 2 : 1))
			0: return kvlp_pkg::CH_SP;
			1: return kvlp_pkg::CH_TAB;
			default: return kvlp_pkg::CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] key_char();
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0: c = any_byte();
			1: c = blank_char(1'b1);
			default: c = 8'($urandom_range(33, 126));
		endcase
		return (c == kvlp_pkg::CH_EQ) ? kvlp_pkg::CH_CR : c;
	endfunction

	function automatic logic [7:0] value_char();
		case ($urandom_range(0, 9))
			0, 1: return any_byte();
			2: return $urandom_range(0, 1) ? kvlp_pkg::CH_DQ : kvlp_pkg::CH_SQ;
			3: return blank_char(1'b1);
			default: return 8'($urandom_range(33, 126));
		endcase
	endfunction

	function automatic line_shape_t pick_shape();
		case ($urandom_range(0, 13))
			0: return SHAPE_COMMENT;
			1: return SHAPE_BLANK;
			2: return SHAPE_NO_EQ;
			3: return SHAPE_EMPTY_KEY;
			4, 5: return SHAPE_NOISE;
			default: return SHAPE_ENTRY;
		endcase
	endfunction

	task automatic send_random_line(input line_shape_t shape);
		logic [7:0] txt [$];
		logic [7:0] q_open, q_close;
		bit quoted, eoc_on_last;
		int pick;
		case (shape)
			SHAPE_ENTRY: begin
				repeat ($urandom_range(0, 2)) txt.push_back(blank_char(1'b1));
				txt.push_back(8'($urandom_range(8'h41, 8'h5a)));
				repeat ($urandom_range(0, 5)) txt.push_back(key_char());
				repeat ($urandom_range(0, 2)) txt.push_back(blank_char(1'b0));
				txt.push_back(kvlp_pkg::CH_EQ);
				repeat ($urandom_range(0, 1)) txt.push_back(blank_char(1'b0));
				quoted = $urandom_range(0, 1);
				q_open = $urandom_range(0, 1) ? kvlp_pkg::CH_DQ : kvlp_pkg::CH_SQ;
				q_close = q_open;
				if ($urandom_range(0, 3) == 0)
					q_close = (q_open == kvlp_pkg::CH_DQ) ? kvlp_pkg::CH_SQ : kvlp_pkg::CH_DQ;
				if (quoted)
					txt.push_back(q_open);
				repeat ($urandom_range(0, 8)) txt.push_back(value_char());
				if (quoted)
					txt.push_back(q_close);
				if ($urandom_range(0, 1))
					txt.push_back(kvlp_pkg::CH_CR);
			end
			SHAPE_COMMENT: begin
				repeat ($urandom_range(0, 2)) txt.push_back(blank_char(1'b1));
				txt.push_back(kvlp_pkg::CH_HASH);
				repeat ($urandom_range(0, 6)) txt.push_back(value_char());
			end
			SHAPE_BLANK: begin
				repeat ($urandom_range(0, 4)) txt.push_back(blank_char(1'b1));
			end
			SHAPE_NO_EQ: begin
				repeat ($urandom_range(1, 8)) txt.push_back(key_char());
			end
			SHAPE_EMPTY_KEY: begin
				repeat ($urandom_range(0, 3)) txt.push_back(blank_char(1'b1));
				txt.push_back(kvlp_pkg::CH_EQ);
				repeat ($urandom_range(0, 5)) txt.push_back(value_char());
			end
			SHAPE_NOISE: begin
				repeat ($urandom_range(1, 12)) txt.push_back(8'($urandom_range(0, 255)));
			end
			SHAPE_FULL: begin
				txt.push_back(8'h4c);
				repeat (30) txt.push_back(key_char());
				txt.push_back(kvlp_pkg::CH_EQ);
				repeat (32) txt.push_back(value_char());
			end
			default: begin
				repeat ($urandom_range(65, 72)) txt.push_back(value_char());
			end
		endcase
		pick = $urandom_range(0, 9);
		eoc_on_last = (pick >= 7) && (pick <= 8) && (txt.size() > 0);
		foreach (txt[i])
			send_text_byte(txt[i], eoc_on_last && (i == txt.size() - 1));
		if (!eoc_on_last)
			send_text_byte(kvlp_pkg::CH_NL, pick >= 7);
		random_bytes += txt.size() + (eoc_on_last ? 0 : 1);
	endtask

	initial begin
		int lines;
		arst_n = 1'b0;
		text_valid = 1'b0;
		text_byte = 8'h00;
		end_of_content = 1'b0;
		burst_left = 0;
		random_bytes = 0;
		hold_req = 1'b0;
		sb = new();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty line closed by a newline carrying the end mark
		send_text_byte(kvlp_pkg::CH_NL, 1'b1);
		// leading tab, cr kept inside key, trailing space trimmed, quotes and cr dropped
		send_str("\011K\015 ='v'\015\n", 1'b0);
		send_str("#=\n", 1'b0);
		send_str("=\n", 1'b0);
		send_str("\015\011", 1'b1);
		// quoted empty value ends on the key byte
		send_str("q=''", 1'b1);
		send_text_byte(8'hff, 1'b0);
		send_text_byte(kvlp_pkg::CH_EQ, 1'b0);
		send_text_byte(8'h00, 1'b0);
		send_text_byte(kvlp_pkg::CH_NL, 1'b1);
		send_str("x", 1'b1);
		wait_drained();

		hold_req = 1'b1;
		lines = 0;
		while (random_bytes < RANDOM_BYTES || lines < 4) begin
			if (lines == 1)
				send_random_line(SHAPE_FULL);
			else if (lines == 3)
				send_random_line(SHAPE_OVERFLOW);
			else if (lines < 1)
				send_random_line(SHAPE_ENTRY);
			else
				send_random_line(pick_shape());
			if (lines == 2)
				wait_drained();
			lines++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/kvlp_pkg.sv
rtl/core/kvlp_line_ram.sv
rtl/core/kvlp_scan.sv
rtl/core/kvlp_reader.sv
rtl/core/key_value_line_parser.sv
tb/key_value_line_parser_tb.sv
